/* rtl/core/tcs_pkg.sv */
package tcs_pkg;

   // Screen geometry defaults.
   localparam int COLUMNS_DEFAULT = 80;
   localparam int ROWS_DEFAULT    = 25;

   // Field widths of the stream payloads.
   localparam int ACTION_W     = 2;
   localparam int CHAR_W       = 8;
   localparam int INDEX_W      = 11;
   localparam int ROW_OUT_W    = 5;
   localparam int COL_OUT_W    = 7;
   localparam int POS_OUT_W    = 11;
   localparam int REQ_TDATA_W  = 24;
   localparam int RSP_TDATA_W  = 32;

   // Action codes carried on req_tuser.
   localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

   // Character codes with a special meaning.
   localparam logic [CHAR_W-1:0] CODE_BS    = 8'h08;
   localparam logic [CHAR_W-1:0] CODE_NL    = 8'h0A;
   localparam logic [CHAR_W-1:0] CODE_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CODE_SPACE = 8'h20;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_ADDR,
      ST_WRITE,
      ST_READ,
      ST_FINISH
   } tcs_state_type;

endpackage

/* rtl/core/tcs_screen_mem.sv */
module tcs_screen_mem #(
   parameter int DEPTH = tcs_pkg::COLUMNS_DEFAULT * tcs_pkg::ROWS_DEFAULT,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [ADDR_W-1:0]         wr_addr,
   input  logic [tcs_pkg::CHAR_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]         rd_addr,
   output logic [tcs_pkg::CHAR_W-1:0] rd_data
);

   logic [tcs_pkg::CHAR_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

/* rtl/core/text_terminal_cursor_scroll.sv */
// Character terminal engine. The screen is one single-port-write, registered-read
// memory of ROWS x COLUMNS cells addressed through a circular top-row pointer, so a
// scroll only moves the pointer and marks the new bottom row blank; clear and reset
// mark every row blank at once. A row marked blank reads as spaces and is swept to
// spaces, one cell per cycle through the memory write port, by the first write that
// lands in it. Items are handled one at a time. A carriage return, a newline, a
// backspace at column 0, a clear, a read beyond the screen or the unused action
// goes from the execute step to the finish step, which registers the result. A
// read of a screen cell adds a read step; a stored character or a backspace that
// moves the cursor adds an address step and a write step, which sweeps the whole
// row when that write is the first into a blank row. The next transaction can be
// accepted in the cycle after the result is registered. The finish step also waits
// while an earlier result is still held. There is no clearing pass after reset. A
// result waits in an output register while the next transaction is accepted.
module text_terminal_cursor_scroll #(
   parameter int COLUMNS = tcs_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = tcs_pkg::ROWS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [7:0] char_code, [18:8] cell_index, [23:19] zero
   input  logic [tcs_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // [1:0] action
   input  logic [tcs_pkg::ACTION_W-1:0]       req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [7:0] read_char, [12:8] cursor_row, [19:13] cursor_col, [30:20] cursor_pos, [31] zero
   output logic [tcs_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);

   localparam int CELLS     = ROWS * COLUMNS;
   localparam int ADDR_W    = $clog2(CELLS);
   localparam int ROW_W     = $clog2(ROWS);
   localparam int COL_W     = $clog2(COLUMNS + 1);
   localparam int CIDX_W    = $clog2(COLUMNS);
   localparam int IDX_W     = tcs_pkg::INDEX_W;
   localparam int CHAR_W    = tcs_pkg::CHAR_W;
   // Reciprocal for cell_index / COLUMNS, exact for every index below 2**IDX_W.
   localparam int DIV_SHIFT = IDX_W + $clog2(COLUMNS);
   localparam int DIV_MULT  = ((2 ** DIV_SHIFT) + COLUMNS - 1) / COLUMNS;
   localparam int MULT_W    = 13;
   localparam int PROD_W    = IDX_W + MULT_W;

   tcs_pkg::tcs_state_type state_ff, state_in;

   logic [tcs_pkg::ACTION_W-1:0] act_ff, act_in;
   logic [CHAR_W-1:0]            code_ff, code_in;
   logic [IDX_W-1:0]             idx_ff, idx_in;
   logic [ROW_W-1:0]             cur_row_ff, cur_row_in;
   logic [COL_W-1:0]             cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]             top_ff, top_in;
   logic [ADDR_W-1:0]            base_ff, base_in;
   logic [ROWS-1:0]              row_valid_ff, row_valid_in;
   logic [CIDX_W-1:0]            wr_col_ff, wr_col_in;
   logic [CHAR_W-1:0]            wr_data_ff, wr_data_in;
   logic [ROW_W-1:0]             phys_ff, phys_in;
   logic [ADDR_W-1:0]            rowbase_ff, rowbase_in;
   logic [CIDX_W-1:0]            fill_cnt_ff, fill_cnt_in;
   logic [ROW_W-1:0]             quot_ff, quot_in;
   logic [CHAR_W-1:0]            got_ff, got_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [tcs_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                mem_we;
   logic [ADDR_W-1:0]   mem_waddr;
   logic [CHAR_W-1:0]   mem_wdata;
   logic [ADDR_W-1:0]   mem_raddr;
   logic [CHAR_W-1:0]   mem_rdata;

   logic [PROD_W-1:0]   div_prod;
   logic [ADDR_W:0]     rd_sum;
   logic [ROW_W:0]      cur_phys_sum;
   logic [ROW_W-1:0]    cur_phys;
   logic [ROW_W:0]      quot_phys_sum;
   logic [ROW_W-1:0]    quot_phys;
   logic [ADDR_W:0]     base_sum;
   logic [ROW_W-1:0]    top_next;
   logic                idx_in_range;
   logic [31:0]         row_ext;
   logic [31:0]         col_ext;
   logic [31:0]         pos_ext;

   tcs_screen_mem #(
      .DEPTH(CELLS)
   ) u_screen_mem (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_waddr),
      .wr_data(mem_wdata),
      .rd_addr(mem_raddr),
      .rd_data(mem_rdata)
   );

   // Address arithmetic shared by several states.
   always_comb begin
      div_prod     = PROD_W'(idx_ff) * PROD_W'(DIV_MULT);
      idx_in_range = (32'(idx_ff) < CELLS);

      rd_sum = (ADDR_W + 1)'(idx_ff) + {1'b0, base_ff};
      if (rd_sum >= (ADDR_W + 1)'(CELLS)) begin
         rd_sum = rd_sum - (ADDR_W + 1)'(CELLS);
      end

      cur_phys_sum = {1'b0, cur_row_ff} + {1'b0, top_ff};
      if (cur_phys_sum >= (ROW_W + 1)'(ROWS)) begin
         cur_phys_sum = cur_phys_sum - (ROW_W + 1)'(ROWS);
      end
      cur_phys = cur_phys_sum[ROW_W-1:0];

      quot_phys_sum = {1'b0, quot_ff} + {1'b0, top_ff};
      if (quot_phys_sum >= (ROW_W + 1)'(ROWS)) begin
         quot_phys_sum = quot_phys_sum - (ROW_W + 1)'(ROWS);
      end
      quot_phys = quot_phys_sum[ROW_W-1:0];

      if (32'(top_ff) == ROWS - 1) begin
         top_next = '0;
      end else begin
         top_next = top_ff + ROW_W'(1);
      end
      base_sum = {1'b0, base_ff} + (ADDR_W + 1)'(COLUMNS);
      if (base_sum >= (ADDR_W + 1)'(CELLS)) begin
         base_sum = base_sum - (ADDR_W + 1)'(CELLS);
      end

      row_ext = 32'(cur_row_ff);
      col_ext = 32'(cur_col_ff);
      pos_ext = row_ext * COLUMNS + col_ext;
   end

   // Items are handled one at a time, so a memory read never overlaps a write
   // to the same cell.
   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      code_in      = code_ff;
      idx_in       = idx_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      top_in       = top_ff;
      base_in      = base_ff;
      row_valid_in = row_valid_ff;
      wr_col_in    = wr_col_ff;
      wr_data_in   = wr_data_ff;
      phys_in      = phys_ff;
      rowbase_in   = rowbase_ff;
      fill_cnt_in  = fill_cnt_ff;
      quot_in      = quot_ff;
      got_in       = got_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      mem_we       = 1'b0;
      mem_waddr    = rowbase_ff + ADDR_W'(wr_col_ff);
      mem_wdata    = wr_data_ff;
      mem_raddr    = rd_sum[ADDR_W-1:0];
      req_tready   = 1'b0;

      case (state_ff)
         tcs_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               act_in   = req_tuser;
               code_in  = req_tdata[CHAR_W-1:0];
               idx_in   = req_tdata[CHAR_W +: IDX_W];
               state_in = tcs_pkg::ST_EXEC;
            end
         end

         tcs_pkg::ST_EXEC: begin
            got_in   = '0;
            state_in = tcs_pkg::ST_FINISH;
            case (act_ff)
               tcs_pkg::ACT_PUT: begin
                  if (code_ff == tcs_pkg::CODE_CR) begin
                     cur_col_in = '0;
                  end else if (code_ff == tcs_pkg::CODE_BS) begin
                     if (cur_col_ff != '0) begin
                        cur_col_in = cur_col_ff - COL_W'(1);
                        wr_col_in  = CIDX_W'(cur_col_ff - COL_W'(1));
                        wr_data_in = tcs_pkg::CODE_SPACE;
                        state_in   = tcs_pkg::ST_ADDR;
                     end
                  end else begin
                     // A newline, or any other byte with a wrap pending, moves
                     // down one row; on the bottom row the screen scrolls instead.
                     if (code_ff == tcs_pkg::CODE_NL || 32'(cur_col_ff) == COLUMNS) begin
                        if (32'(cur_row_ff) == ROWS - 1) begin
                           top_in               = top_next;
                           base_in              = base_sum[ADDR_W-1:0];
                           row_valid_in[top_ff] = 1'b0;
                        end else begin
                           cur_row_in = cur_row_ff + ROW_W'(1);
                        end
                     end
                     if (code_ff == tcs_pkg::CODE_NL) begin
                        cur_col_in = '0;
                     end else begin
                        if (32'(cur_col_ff) == COLUMNS) begin
                           wr_col_in  = '0;
                           cur_col_in = COL_W'(1);
                        end else begin
                           wr_col_in  = CIDX_W'(cur_col_ff);
                           cur_col_in = cur_col_ff + COL_W'(1);
                        end
                        wr_data_in = code_ff;
                        state_in   = tcs_pkg::ST_ADDR;
                     end
                  end
               end

               tcs_pkg::ACT_READ: begin
                  if (idx_in_range) begin
                     quot_in  = div_prod[DIV_SHIFT +: ROW_W];
                     state_in = tcs_pkg::ST_READ;
                  end
               end

               tcs_pkg::ACT_CLEAR: begin
                  row_valid_in = '0;
                  top_in       = '0;
                  base_in      = '0;
                  cur_row_in   = '0;
                  cur_col_in   = '0;
               end

               default: begin
                  state_in = tcs_pkg::ST_FINISH;
               end
            endcase
         end

         tcs_pkg::ST_ADDR: begin
            phys_in     = cur_phys;
            rowbase_in  = ADDR_W'(32'(cur_phys) * COLUMNS);
            fill_cnt_in = '0;
            state_in    = tcs_pkg::ST_WRITE;
         end

         tcs_pkg::ST_WRITE: begin
            mem_we = 1'b1;
            if (row_valid_ff[phys_ff]) begin
               state_in = tcs_pkg::ST_FINISH;
            end else begin
               // Blank row: sweep it to spaces, dropping the new byte in on the way.
               mem_waddr   = rowbase_ff + ADDR_W'(fill_cnt_ff);
               mem_wdata   = (fill_cnt_ff == wr_col_ff) ? wr_data_ff : tcs_pkg::CODE_SPACE;
               fill_cnt_in = fill_cnt_ff + CIDX_W'(1);
               if (32'(fill_cnt_ff) == COLUMNS - 1) begin
                  row_valid_in[phys_ff] = 1'b1;
                  state_in              = tcs_pkg::ST_FINISH;
               end
            end
         end

         tcs_pkg::ST_READ: begin
            got_in   = row_valid_ff[quot_phys] ? mem_rdata : tcs_pkg::CODE_SPACE;
            state_in = tcs_pkg::ST_FINISH;
         end

         tcs_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {1'b0, pos_ext[tcs_pkg::POS_OUT_W-1:0],
                               col_ext[tcs_pkg::COL_OUT_W-1:0],
                               row_ext[tcs_pkg::ROW_OUT_W-1:0], got_ff};
               rsp_valid_in = 1'b1;
               state_in     = tcs_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = tcs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcs_pkg::ST_IDLE;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         top_ff       <= '0;
         base_ff      <= '0;
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         top_ff       <= top_in;
         base_ff      <= base_in;
         row_valid_ff <= row_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      code_ff     <= code_in;
      idx_ff      <= idx_in;
      wr_col_ff   <= wr_col_in;
      wr_data_ff  <= wr_data_in;
      phys_ff     <= phys_in;
      rowbase_ff  <= rowbase_in;
      fill_cnt_ff <= fill_cnt_in;
      quot_ff     <= quot_in;
      got_ff      <= got_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      32'(cur_col_ff) <= COLUMNS)
      else $error("cursor column beyond the wrap position");

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      32'(cur_row_ff) < ROWS && 32'(top_ff) < ROWS)
      else $error("cursor row or top row out of range");

   a_base_tracks_top: assert property (@(posedge clock) disable iff (reset)
      32'(base_ff) == 32'(top_ff) * COLUMNS)
      else $error("top-row base address lost track of the top row");

   a_write_in_screen: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> 32'(mem_waddr) < CELLS)
      else $error("screen write outside the screen");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == tcs_pkg::ST_FINISH)
      else $error("result raised outside the finish step");

endmodule

/* verif/testbench.sv */
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import tcs_pkg::*;

   localparam int COLUMNS       = COLUMNS_DEFAULT;
   localparam int ROWS          = ROWS_DEFAULT;
   localparam int CELLS         = COLUMNS * ROWS;
   localparam int RANDOM_ITEMS  = 900;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 120;
   localparam int DRAIN_LIMIT   = 5000;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int PRINT_LIMIT   = 40;

   // Action 3 has no meaning in the block; it must leave everything alone.
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   typedef enum int {
      READY_ALWAYS,
      READY_HALF,
      READY_SPARSE,
      READY_MOSTLY
   } ready_mode_type;

   typedef struct packed {
      logic [CHAR_W-1:0]    read_char;
      logic [ROW_OUT_W-1:0] row;
      logic [COL_OUT_W-1:0] col;
      logic [POS_OUT_W-1:0] pos;
   } cursor_report_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [ACTION_W-1:0]    req_tuser = ACT_PUT;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   // Screen contents and cursor as the block should hold them.
   logic [CHAR_W-1:0] screen_model [CELLS];
   int                model_row;
   int                model_col;
   cursor_report_type expected_reports [$];

   int error_count = 0;
   int cycle_count = 0;
   int burst_left  = 0;
   bit hold_request = 1'b0;

   text_terminal_cursor_scroll #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL text_terminal_cursor_scroll");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("mismatch at cycle %0d: %s, got %0d, expected %0d",
                  cycle_count, what, got, want);
   endtask

   function automatic void blank_screen_model();
      int i;
      for (i = 0; i < CELLS; i++)
         screen_model[i] = CODE_SPACE;
      model_row = 0;
      model_col = 0;
   endfunction

   function automatic void advance_model_row();
      int i;
      model_row++;
      if (model_row >= ROWS) begin
         for (i = 0; i < CELLS - COLUMNS; i++)
            screen_model[i] = screen_model[i + COLUMNS];
         for (i = CELLS - COLUMNS; i < CELLS; i++)
            screen_model[i] = CODE_SPACE;
         model_row = ROWS - 1;
      end
   endfunction

   function automatic void put_model_char(input logic [CHAR_W-1:0] ch);
      if (ch == CODE_CR) begin
         model_col = 0;
      end else if (ch == CODE_BS) begin
         if (model_col > 0) begin
            model_col--;
            screen_model[model_row * COLUMNS + model_col] = CODE_SPACE;
         end
      end else if (ch == CODE_NL) begin
         model_col = 0;
         advance_model_row();
      end else begin
         // A column equal to COLUMNS means the wrap is still pending.
         if (model_col >= COLUMNS) begin
            model_col = 0;
            advance_model_row();
         end
         screen_model[model_row * COLUMNS + model_col] = ch;
         model_col++;
      end
   endfunction

   function automatic void predict_report(input logic [ACTION_W-1:0] act,
                                          input logic [CHAR_W-1:0] ch,
                                          input logic [INDEX_W-1:0] idx);
      cursor_report_type rep;
      rep.read_char = '0;
      case (act)
         ACT_PUT:   put_model_char(ch);
         ACT_READ:  if (idx < CELLS) rep.read_char = screen_model[idx];
         ACT_CLEAR: blank_screen_model();
         default:   ;
      endcase
      rep.row = ROW_OUT_W'(model_row);
      rep.col = COL_OUT_W'(model_col);
      rep.pos = POS_OUT_W'(model_row * COLUMNS + model_col);
      expected_reports.push_back(rep);
   endfunction

   // Offers one transaction, idling between bursts, and predicts its result once taken.
   task automatic send_request(input logic [ACTION_W-1:0] act,
                               input logic [CHAR_W-1:0] ch,
                               input logic [INDEX_W-1:0] idx);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0)
            gap = $urandom_range(1, 8);
      end
      burst_left--;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {{(REQ_TDATA_W - CHAR_W - INDEX_W){1'b0}}, idx, ch};
      do @(posedge clock); while (!req_tready);
      predict_report(act, ch, idx);
   endtask

   task automatic put_char(input logic [CHAR_W-1:0] ch);
      send_request(ACT_PUT, ch, INDEX_W'($urandom));
   endtask

   task automatic read_cell(input int idx);
      send_request(ACT_READ, CHAR_W'($urandom), INDEX_W'(idx));
   endtask

   task automatic put_text_run(input int count);
      repeat (count) put_char(CHAR_W'($urandom_range(8'h21, 8'h7E)));
   endtask

   // Receiver: ready pattern changes every so often; a hold request stalls it for long.
   initial begin : rsp_ready_driver
      ready_mode_type mode;
      int             mode_left;
      int             hold_count;
      mode = READY_ALWAYS;
      mode_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_tready <= 1'b0;
            for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++)
               @(posedge clock);
            hold_request = 1'b0;
         end
         if (mode_left == 0) begin
            mode = ready_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(16, 128);
         end
         mode_left--;
         case (mode)
            READY_ALWAYS: rsp_tready <= 1'b1;
            READY_HALF:   rsp_tready <= 1'($urandom_range(0, 1));
            READY_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
            default:      rsp_tready <= ($urandom_range(0, 15) != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      cursor_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_reports.size() == 0) begin
            report_mismatch("result with no transaction pending", int'(rsp_tdata), 0);
         end else begin
            want = expected_reports.pop_front();
            if (rsp_tdata[7:0] !== want.read_char)
               report_mismatch("read_char", int'(rsp_tdata[7:0]), int'(want.read_char));
            if (rsp_tdata[12:8] !== want.row)
               report_mismatch("cursor_row", int'(rsp_tdata[12:8]), int'(want.row));
            if (rsp_tdata[19:13] !== want.col)
               report_mismatch("cursor_col", int'(rsp_tdata[19:13]), int'(want.col));
            if (rsp_tdata[30:20] !== want.pos)
               report_mismatch("cursor_pos", int'(rsp_tdata[30:20]), int'(want.pos));
         end
      end
   end

   // Control codes, field extremes, out-of-range reads and the unused action.
   task automatic test_control_codes();
      read_cell(0);
      read_cell(CELLS - 1);
      read_cell(CELLS);
      read_cell((1 << INDEX_W) - 1);
      put_char(8'h48);
      put_char(8'h00);
      put_char(8'hFF);
      read_cell(1);
      read_cell(2);
      put_char(CODE_BS);
      read_cell(2);
      put_char(CODE_CR);
      put_char(CODE_BS);
      put_char(CODE_NL);
      send_request(ACT_UNUSED, 8'hFF, INDEX_W'((1 << INDEX_W) - 1));
      send_request(ACT_CLEAR, 8'hFF, INDEX_W'((1 << INDEX_W) - 1));
      read_cell(0);
   endtask

   // Pending wrap, backspace and newline across it, and scrolling off the bottom.
   task automatic test_wrap_and_scroll();
      put_text_run(COLUMNS);
      put_char(CODE_BS);
      read_cell(COLUMNS - 1);
      put_char(8'h57);
      put_char(8'h58);
      read_cell(COLUMNS);
      put_text_run(COLUMNS - 1);
      put_char(CODE_NL);
      repeat (ROWS - 2) put_char(CODE_NL);
      put_text_run(COLUMNS);
      put_char(8'h59);
      read_cell(0);
      read_cell(CELLS - 2 * COLUMNS);
      read_cell(CELLS - COLUMNS);
      put_char(CODE_NL);
      read_cell(CELLS - 2 * COLUMNS);
      send_request(ACT_CLEAR, 8'h00, '0);
   endtask

   task automatic test_random_traffic();
      int r;
      int idx;
      repeat (RANDOM_ITEMS) begin
         r = $urandom_range(0, 999);
         if (r < 420)
            put_char(CHAR_W'($urandom_range(8'h21, 8'h7E)));
         else if (r < 550)
            put_char(CHAR_W'($urandom));
         else if (r < 630)
            put_char(CODE_NL);
         else if (r < 660)
            put_char(CODE_CR);
         else if (r < 700)
            put_char(CODE_BS);
         else if (r < 975) begin
            case ($urandom_range(0, 3))
               0, 1: idx = model_row * COLUMNS + $urandom_range(0, COLUMNS - 1);
               2:    idx = $urandom_range(0, CELLS - 1);
               default: idx = $urandom_range(0, (1 << INDEX_W) - 1);
            endcase
            read_cell(idx);
         end else if (r < 995)
            send_request(ACT_UNUSED, CHAR_W'($urandom), INDEX_W'($urandom));
         else
            send_request(ACT_CLEAR, CHAR_W'($urandom), INDEX_W'($urandom));
      end
   endtask

   // The receiver stops for a long time while slow row-opening writes keep coming.
   task automatic test_backpressure();
      int i;
      hold_request = 1'b1;
      for (i = 0; i < 12; i++) begin
         put_char(CODE_NL);
         put_char(CHAR_W'($urandom_range(8'h21, 8'h7E)));
         read_cell(model_row * COLUMNS);
      end
   endtask

   initial begin : main
      int drain_count;
      blank_screen_model();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_control_codes();
      test_wrap_and_scroll();
      test_backpressure();
      test_random_traffic();
      req_tvalid <= 1'b0;
      drain_count = 0;
      while (expected_reports.size() != 0 && drain_count < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_count++;
      end
      if (expected_reports.size() != 0)
         report_mismatch("results never delivered", expected_reports.size(), 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("PASS text_terminal_cursor_scroll");
      else
         $display("FAIL text_terminal_cursor_scroll");
      $finish;
   end

endmodule
